// ===== rtl/core/heightmap_height_query_macros.svh =====
// Assertion macros shared by the height query RTL.
`ifndef HEIGHTMAP_HEIGHT_QUERY_MACROS_SVH
`define HEIGHTMAP_HEIGHT_QUERY_MACROS_SVH
`ifndef SYNTHESIS
`define HHQ_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HHQ_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define HHQ_ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define HHQ_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/core/hhq_pkg.sv =====
`default_nettype none
package hhq_pkg;

  localparam int MAX_GRID_DIM_DEF = 127;
  localparam int STORE_DEPTH_DEF  = 16384;
  localparam int FRAC_BITS_DEF    = 12;

  localparam logic [1:0] CFG_CELL_SIZE = 2'd0;
  localparam logic [1:0] CFG_GRID_COLS = 2'd1;
  localparam logic [1:0] CFG_GRID_ROWS = 2'd2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [15:0] CELL_SIZE_RST = 16'd256;
  localparam logic [6:0]  GRID_DIM_RST  = 7'd127;
  localparam logic [15:0] HEIGHT_MAX    = 16'd65280;

  typedef struct packed {
    logic               req_type;
    logic [13:0]        sample_index;
    logic [7:0]         sample_value;
    logic signed [23:0] query_x;
    logic signed [23:0] query_z;
  } req_t;

  typedef struct packed {
    logic [15:0] height_y;
    logic        out_of_range;
  } rsp_t;

  typedef struct packed {
    logic valid;
    logic query;
    logic oor;
  } ctl_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [13:0] idx;
    logic [7:0]  val;
  } side_t;

endpackage
`default_nettype wire

// ===== rtl/core/hhq_chan_if.sv =====
`default_nettype none
interface hhq_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/hhq_ram.sv =====
`default_nettype none
module hhq_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16384,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/hhq_divpipe.sv =====
`default_nettype none
module hhq_divpipe #(
  parameter int FRAC_BITS = 12,
  localparam int DW       = 24 + FRAC_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire logic [15:0]   size,
  input  wire hhq_pkg::side_t in_side,
  input  wire logic [23:0]   ux,
  input  wire logic [23:0]   uz,
  output hhq_pkg::side_t     out_side,
  output logic      [DW-1:0] out_qx,
  output logic      [DW-1:0] out_qz
);
  import hhq_pkg::*;

  // Each stage retires one quotient bit; the word shifts dividend bits out
  // at the top and quotient bits in at the bottom.
  side_t           side_r [DW];
  logic [15:0]     remx_r [DW];
  logic [15:0]     remz_r [DW];
  logic [DW-1:0]   wx_r   [DW];
  logic [DW-1:0]   wz_r   [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    side_t         s_in;
    logic [15:0]   rxi;
    logic [15:0]   rzi;
    logic [DW-1:0] wxi;
    logic [DW-1:0] wzi;
    logic [16:0]   tx;
    logic [16:0]   tz;
    logic          gx;
    logic          gz;

    if (k == 0) begin : g_first
      assign s_in = in_side;
      assign rxi  = '0;
      assign rzi  = '0;
      assign wxi  = {ux, {FRAC_BITS{1'b0}}};
      assign wzi  = {uz, {FRAC_BITS{1'b0}}};
    end else begin : g_next
      assign s_in = side_r[k-1];
      assign rxi  = remx_r[k-1];
      assign rzi  = remz_r[k-1];
      assign wxi  = wx_r[k-1];
      assign wzi  = wz_r[k-1];
    end

    assign tx = {rxi, wxi[DW-1]};
    assign tz = {rzi, wzi[DW-1]};
    assign gx = tx >= {1'b0, size};
    assign gz = tz >= {1'b0, size};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k] <= '0;
      end else if (adv) begin
        side_r[k] <= s_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        remx_r[k] <= gx ? 16'(tx - {1'b0, size}) : tx[15:0];
        remz_r[k] <= gz ? 16'(tz - {1'b0, size}) : tz[15:0];
        wx_r[k]   <= {wxi[DW-2:0], gx};
        wz_r[k]   <= {wzi[DW-2:0], gz};
      end
    end
  end

  assign out_side = side_r[DW-1];
  assign out_qx   = wx_r[DW-1];
  assign out_qz   = wz_r[DW-1];
endmodule
`default_nettype wire

// ===== rtl/core/hhq_lookup.sv =====
`default_nettype none
module hhq_lookup #(
  parameter int STORE_DEPTH = 16384,
  parameter int FRAC_BITS   = 12,
  localparam int DW         = 24 + FRAC_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire logic [6:0]           grid_cols,
  input  wire logic [6:0]           grid_rows,
  input  wire hhq_pkg::side_t       in_side,
  input  wire logic [DW-1:0]        qx,
  input  wire logic [DW-1:0]        qz,
  output hhq_pkg::ctl_t             out_ctl,
  output logic      [FRAC_BITS-1:0] out_fx,
  output logic      [FRAC_BITS-1:0] out_fz,
  output logic      [7:0]           out_h [4]
);
  import hhq_pkg::*;

  localparam int IW = 17;
  localparam int AW = $clog2(STORE_DEPTH);

  logic [23:0]          col;
  logic [23:0]          row;
  logic [7:0]           stride;
  logic                 cell_bad;
  logic [IW-1:0]        i0_nxt;
  side_t                e1_side_nxt;
  side_t                e1_side_r;
  logic [IW-1:0]        e1_i0_r;
  logic [7:0]           e1_stride_r;
  logic [FRAC_BITS-1:0] e1_fx_r;
  logic [FRAC_BITS-1:0] e1_fz_r;
  logic [IW-1:0]        rd_idx [4];
  logic                 vtx_bad;
  logic                 ram_we;
  ctl_t                 e2_ctl_nxt;
  ctl_t                 e2_ctl_r;
  logic [FRAC_BITS-1:0] e2_fx_r;
  logic [FRAC_BITS-1:0] e2_fz_r;

  assign col      = qx[DW-1:FRAC_BITS];
  assign row      = qz[DW-1:FRAC_BITS];
  assign stride   = {1'b0, grid_cols} + 8'd1;
  assign cell_bad = (col >= 24'(grid_cols)) || (row >= 24'(grid_rows));
  assign i0_nxt   = IW'(row[6:0]) * IW'(stride) + IW'(col[6:0]);

  always_comb begin
    e1_side_nxt         = in_side;
    e1_side_nxt.ctl.oor = in_side.ctl.oor || (in_side.ctl.query && cell_bad);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_side_r <= '0;
    end else if (adv) begin
      e1_side_r <= e1_side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_i0_r     <= i0_nxt;
      e1_stride_r <= stride;
      e1_fx_r     <= qx[FRAC_BITS-1:0];
      e1_fz_r     <= qz[FRAC_BITS-1:0];
    end
  end

  // Vertex order: cell corner, next row, next column, diagonal corner.
  assign rd_idx[0] = e1_i0_r;
  assign rd_idx[1] = e1_i0_r + IW'(e1_stride_r);
  assign rd_idx[2] = e1_i0_r + IW'(1);
  assign rd_idx[3] = rd_idx[1] + IW'(1);
  assign vtx_bad   = rd_idx[3] >= IW'(STORE_DEPTH);
  assign ram_we    = adv && e1_side_r.ctl.valid && (e1_side_r.ctl.query == REQ_LOAD) &&
                     (IW'(e1_side_r.idx) < IW'(STORE_DEPTH));

  for (genvar v = 0; v < 4; v++) begin : g_ram
    hhq_ram #(
      .W     (8),
      .DEPTH (STORE_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (AW'(e1_side_r.idx)),
      .wdata (e1_side_r.val),
      .re    (adv),
      .raddr (rd_idx[v][AW-1:0]),
      .rdata (out_h[v])
    );
  end

  always_comb begin
    e2_ctl_nxt     = e1_side_r.ctl;
    e2_ctl_nxt.oor = e1_side_r.ctl.oor || (e1_side_r.ctl.query && vtx_bad);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2_ctl_r <= '0;
    end else if (adv) begin
      e2_ctl_r <= e2_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e2_fx_r <= e1_fx_r;
      e2_fz_r <= e1_fz_r;
    end
  end

  assign out_ctl = e2_ctl_r;
  assign out_fx  = e2_fx_r;
  assign out_fz  = e2_fz_r;
endmodule
`default_nettype wire

// ===== rtl/core/hhq_blend.sv =====
`default_nettype none
module hhq_blend #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire hhq_pkg::ctl_t        in_ctl,
  input  wire logic [FRAC_BITS-1:0] fx,
  input  wire logic [FRAC_BITS-1:0] fz,
  input  wire logic [7:0]           h [4],
  output logic                      out_valid,
  output hhq_pkg::rsp_t             out_rsp
);
  import hhq_pkg::*;

  localparam int WW = FRAC_BITS + 1;
  localparam int PW = 8 + WW;
  localparam int SW = PW + 2;
  localparam int YW = SW + 8;
  localparam logic [WW-1:0] ONE  = WW'(1) << FRAC_BITS;
  localparam logic [YW-1:0] HALF = YW'(1) << (FRAC_BITS - 1);

  logic [WW-1:0] fsum;
  logic          lower;
  logic [WW-1:0] wa, wb, wc;
  logic [7:0]    ha, hb, hc;
  ctl_t          e3_ctl_r;
  logic [PW-1:0] pa_r, pb_r, pc_r;
  logic [SW-1:0] acc;
  logic [YW-1:0] yfull;
  logic [15:0]   y16;
  logic          out_valid_r;
  rsp_t          rsp_nxt;
  rsp_t          rsp_r;

  assign fsum  = {1'b0, fx} + {1'b0, fz};
  assign lower = fsum <= ONE;

  always_comb begin
    if (lower) begin
      wa = ONE - fsum;
      ha = h[0];
      wb = {1'b0, fx};
      hb = h[2];
      wc = {1'b0, fz};
      hc = h[1];
    end else begin
      wa = fsum - ONE;
      ha = h[3];
      wb = ONE - {1'b0, fx};
      hb = h[1];
      wc = ONE - {1'b0, fz};
      hc = h[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e3_ctl_r <= '0;
    end else if (adv) begin
      e3_ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r <= PW'(ha) * PW'(wa);
      pb_r <= PW'(hb) * PW'(wb);
      pc_r <= PW'(hc) * PW'(wc);
    end
  end

  assign acc   = SW'(pa_r) + SW'(pb_r) + SW'(pc_r);
  assign yfull = ({acc, 8'd0} + HALF) >> FRAC_BITS;
  assign y16   = (yfull > YW'(HEIGHT_MAX)) ? HEIGHT_MAX : yfull[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= e3_ctl_r.valid;
    end
  end

  always_comb begin
    rsp_nxt = '0;
    if (e3_ctl_r.query && !e3_ctl_r.oor) begin
      rsp_nxt.height_y = y16;
    end else begin
      rsp_nxt.out_of_range = e3_ctl_r.query;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;
endmodule
`default_nettype wire

// ===== rtl/core/heightmap_height_query.sv =====
// Channel   Direction  Payload
// in_ch     sink       req_t: load of one height or query of a world point
// out_ch    source     rsp_t: height in Q8.8 and out-of-range flag
// cfg_*     write      cell_size, grid_cols, grid_rows
//
// One item enters per cycle while the output is not stalled; each result passes through
// the two restoring dividers (one quotient bit a stage), the lookup and the blend.
// Reset clears the valid bits and loads the register defaults; the height
// store holds nothing defined until loaded, and it takes no clearing pass.
// A stalled output freezes every stage at once, so nothing is lost or repeated.
`default_nettype none
`include "heightmap_height_query_macros.svh"
module heightmap_height_query #(
  parameter int MAX_GRID_DIM = hhq_pkg::MAX_GRID_DIM_DEF,
  parameter int STORE_DEPTH  = hhq_pkg::STORE_DEPTH_DEF,
  parameter int FRAC_BITS    = hhq_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  hhq_chan_if.sink         in_ch,
  hhq_chan_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import hhq_pkg::*;

  localparam int DW = 24 + FRAC_BITS;
  localparam logic [6:0] DIM_RST =
    (int'(GRID_DIM_RST) > MAX_GRID_DIM) ? 7'(MAX_GRID_DIM) : GRID_DIM_RST;

  logic                 adv;
  logic [15:0]          cell_size_r;
  logic [6:0]           grid_cols_r;
  logic [6:0]           grid_rows_r;
  logic [6:0]           dim_sat;
  req_t                 req;
  logic                 pre_oor;
  side_t                in_side;
  logic [23:0]          ux;
  logic [23:0]          uz;
  side_t                div_side;
  logic [DW-1:0]        qx;
  logic [DW-1:0]        qz;
  ctl_t                 lk_ctl;
  logic [FRAC_BITS-1:0] lk_fx;
  logic [FRAC_BITS-1:0] lk_fz;
  logic [7:0]           lk_h [4];
  logic                 out_valid;
  rsp_t                 out_rsp;

  assign dim_sat = ({1'b0, cfg_wdata[6:0]} > 8'(MAX_GRID_DIM)) ? 7'(MAX_GRID_DIM)
                                                               : cfg_wdata[6:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r <= CELL_SIZE_RST;
      grid_cols_r <= DIM_RST;
      grid_rows_r <= DIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CELL_SIZE: cell_size_r <= cfg_wdata;
        CFG_GRID_COLS: grid_cols_r <= dim_sat;
        CFG_GRID_ROWS: grid_rows_r <= dim_sat;
        default: ;
      endcase
    end
  end

  assign adv = !out_valid || out_ch.ready;

  assign req     = in_ch.data;
  assign pre_oor = (cell_size_r == 16'd0) || req.query_x[23] ||
                   (!req.query_z[23] && (req.query_z != 24'sd0));
  assign ux      = {1'b0, req.query_x[22:0]};
  assign uz      = 24'(-req.query_z);

  always_comb begin
    in_side.ctl.valid = in_ch.valid;
    in_side.ctl.query = (req.req_type == REQ_QUERY);
    in_side.ctl.oor   = (req.req_type == REQ_QUERY) && pre_oor;
    in_side.idx       = req.sample_index;
    in_side.val       = req.sample_value;
  end

  hhq_divpipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_divpipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .size     (cell_size_r),
    .in_side  (in_side),
    .ux       (ux),
    .uz       (uz),
    .out_side (div_side),
    .out_qx   (qx),
    .out_qz   (qz)
  );

  hhq_lookup #(
    .STORE_DEPTH (STORE_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_lookup (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .grid_cols (grid_cols_r),
    .grid_rows (grid_rows_r),
    .in_side   (div_side),
    .qx        (qx),
    .qz        (qz),
    .out_ctl   (lk_ctl),
    .out_fx    (lk_fx),
    .out_fz    (lk_fz),
    .out_h     (lk_h)
  );

  hhq_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_ctl    (lk_ctl),
    .fx        (lk_fx),
    .fz        (lk_fz),
    .h         (lk_h),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  assign in_ch.ready  = adv;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_rsp;

  `HHQ_ASSERT_IMPL(a_oor_zero, clk, rst_n, out_ch.valid && out_ch.data.out_of_range |-> out_ch.data.height_y == 16'd0, "Out-of-range result carries a nonzero height.")
  `HHQ_ASSERT_IMPL(a_height_cap, clk, rst_n, out_ch.valid |-> out_ch.data.height_y <= HEIGHT_MAX, "Height exceeds the full-scale value.")
  `HHQ_ASSERT_NEVER(a_stall_blocks, clk, rst_n, out_ch.valid && !out_ch.ready && in_ch.ready, "Input taken while the output is stalled.")
endmodule
`default_nettype wire
